// File: hw/rtl/calibration_curve_interpolator_macros.svh
// Assertion helpers for the calibration curve interpolator.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CALIBRATION_CURVE_INTERPOLATOR_MACROS_SVH
`define CALIBRATION_CURVE_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS

`define CCI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define CCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CCI_ASSERT_IMPL(lbl, ante, cons, msg)

`define CCI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/cci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cci_pkg;

  localparam int unsigned MAX_POINTS  = 8;
  localparam int unsigned POINTS_DEF  = 8;
  localparam int unsigned TRAVEL_W    = 16;
  localparam int unsigned VALUE_W     = 15;
  localparam int unsigned PT_IN_W     = 15;
  localparam int unsigned PT_OUT_W    = 16;
  localparam int unsigned CFG_DATA_W  = PT_IN_W + PT_OUT_W;
  localparam int unsigned CFG_IDX_W   = $clog2(MAX_POINTS);
  localparam int unsigned FULL_SCALE  = 25600;

  // Long division: 32 quotient bits, spread over DIV_STAGES pipeline stages.
  localparam int unsigned QUO_W       = 32;
  localparam int unsigned DIV_STAGES  = 8;
  localparam int unsigned DIV_BITS    = QUO_W / DIV_STAGES;
  localparam int unsigned REM_W       = PT_IN_W;
  localparam int unsigned SUM_W       = QUO_W + 2;

  typedef logic signed [TRAVEL_W-1:0] travel_t;
  typedef logic [VALUE_W-1:0]         value_t;
  typedef logic [PT_IN_W-1:0]         pt_in_t;
  typedef logic [PT_OUT_W-1:0]        pt_out_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
  typedef logic [QUO_W-1:0]           quo_t;
  typedef logic [REM_W-1:0]           rem_t;

endpackage

`default_nettype wire

// File: hw/rtl/cci_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cci_travel_if import cci_pkg::*; ();
  logic    valid;
  logic    ready;
  travel_t travel;

  modport source (output valid, output travel, input ready);
  modport sink   (input valid, input travel, output ready);
endinterface

interface cci_curve_if import cci_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t curve_value;

  modport source (output valid, output curve_value, input ready);
  modport sink   (input valid, input curve_value, output ready);
endinterface

interface cci_cfg_if import cci_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/calibration_curve_interpolator.sv
// Piecewise-linear calibration curve. Each travel request (signed Q7.8) is
// clamped to 0..100 percent, matched to the first segment whose upper
// breakpoint is at or above it, and interpolated between the two output
// points of that segment; the quotient truncates toward zero and the result
// saturates to 0..25600. The block takes one request per clock while the
// output is not stalled. Each request passes through clamp, segment
// select, multiply, eight long-division stages of four quotient bits
// each, and the output register. Every stage stalls only when the stage
// after it is full, so empty stages keep accepting requests while a result
// waits to be taken. Calibration points are written through the
// configuration channel, which is always ready; writes to an index at or
// above POINTS are dropped.
`timescale 1ns / 1ps
`default_nettype none

`include "calibration_curve_interpolator_macros.svh"

module calibration_curve_interpolator import cci_pkg::*; #(
  parameter int unsigned POINTS = POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cci_cfg_if.sink     cfg,
  cci_travel_if.sink  sample,
  cci_curve_if.source result
);

  localparam int unsigned DS   = DIV_STAGES;
  localparam int unsigned NSTG = DS + 4;

  // Calibration points
  pt_in_t  pt_in  [POINTS];
  pt_out_t pt_out [POINTS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < POINTS; k++) begin
        pt_in[k]  <= '0;
        pt_out[k] <= '0;
      end
    end else if (cfg.valid && cfg.ready) begin
      for (int k = 0; k < POINTS; k++) begin
        if (cfg.index == CFG_IDX_W'(k)) begin
          pt_in[k]  <= cfg.data[PT_OUT_W +: PT_IN_W];
          pt_out[k] <= cfg.data[PT_OUT_W-1:0];
        end
      end
    end
  end

  // Stage valid bits and the backward ready chain
  logic [NSTG:1]   v;
  logic [NSTG+1:1] rdy;

  always_comb begin
    rdy[NSTG+1] = result.ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign sample.ready = rdy[1];
  assign result.valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= sample.valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: clamp
  value_t x1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      if (sample.travel[TRAVEL_W-1]) begin
        x1 <= '0;
      end else if (sample.travel[VALUE_W-1:0] > VALUE_W'(FULL_SCALE)) begin
        x1 <= VALUE_W'(FULL_SCALE);
      end else begin
        x1 <= sample.travel[VALUE_W-1:0];
      end
    end
  end

  // Stage 2: segment select, operand magnitudes and sign
  pt_in_t                 lo, hi;
  pt_out_t                o0, o1;
  logic                   found;
  logic signed [PT_OUT_W:0] dx, diff;
  logic [PT_OUT_W-1:0]    dx_mag, diff_mag;

  always_comb begin
    found = 1'b0;
    lo    = '0;
    hi    = '0;
    o0    = pt_out[POINTS-1];
    o1    = pt_out[POINTS-1];
    // Walk down so that the lowest matching segment wins.
    for (int k = POINTS - 2; k >= 0; k--) begin
      if ({1'b0, x1} <= {1'b0, pt_in[k+1]}) begin
        found = 1'b1;
        lo    = pt_in[k];
        hi    = pt_in[k+1];
        o0    = pt_out[k];
        o1    = pt_out[k+1];
      end
    end
    dx       = $signed({2'b00, x1}) - $signed({2'b00, lo});
    diff     = $signed({1'b0, o1}) - $signed({1'b0, o0});
    dx_mag   = dx[PT_OUT_W] ? PT_OUT_W'(-dx) : dx[PT_OUT_W-1:0];
    diff_mag = diff[PT_OUT_W] ? PT_OUT_W'(-diff) : diff[PT_OUT_W-1:0];
  end

  pt_out_t             o0_2;
  logic [PT_OUT_W-1:0] dx_mag_2, diff_mag_2;
  logic                neg_2, interp_2;
  pt_in_t              span_2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      o0_2       <= o0;
      dx_mag_2   <= dx_mag;
      diff_mag_2 <= diff_mag;
      neg_2      <= dx[PT_OUT_W] ^ diff[PT_OUT_W];
      interp_2   <= found && (hi > lo);
      span_2     <= hi - lo;
    end
  end

  // Stage 3 (division index 0): product magnitude; stages after it divide.
  quo_t    d_work   [DS+1];
  rem_t    d_rem    [DS+1];
  pt_in_t  d_span   [DS+1];
  pt_out_t d_o0     [DS+1];
  logic    d_neg    [DS+1];
  logic    d_interp [DS+1];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      d_work[0]   <= QUO_W'(diff_mag_2) * QUO_W'(dx_mag_2);
      d_rem[0]    <= '0;
      d_span[0]   <= span_2;
      d_o0[0]     <= o0_2;
      d_neg[0]    <= neg_2;
      d_interp[0] <= interp_2;
    end
  end

  for (genvar j = 1; j <= DS; j++) begin : g_div
    quo_t w;
    rem_t r;

    // Restoring division: dividend bits shift out of the top of the work
    // word while quotient bits shift in at the bottom.
    always_comb begin
      logic [REM_W:0] t;
      logic           ge;
      w = d_work[j-1];
      r = d_rem[j-1];
      for (int b = 0; b < DIV_BITS; b++) begin
        t  = {r, w[QUO_W-1]};
        ge = t >= {1'b0, d_span[j-1]};
        w  = {w[QUO_W-2:0], ge};
        r  = ge ? REM_W'(t - {1'b0, d_span[j-1]}) : t[REM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[3+j]) begin
        d_work[j]   <= w;
        d_rem[j]    <= r;
        d_span[j]   <= d_span[j-1];
        d_o0[j]     <= d_o0[j-1];
        d_neg[j]    <= d_neg[j-1];
        d_interp[j] <= d_interp[j-1];
      end
    end
  end

  // Output stage: apply the sign, add the base point and saturate.
  logic signed [SUM_W-1:0] q_s, base, sum;
  value_t                  sat;
  value_t                  out_q;

  always_comb begin
    q_s  = $signed({2'b00, d_work[DS]});
    base = $signed({{(SUM_W-PT_OUT_W){1'b0}}, d_o0[DS]});
    if (d_neg[DS]) begin
      q_s = -q_s;
    end
    sum = d_interp[DS] ? base + q_s : base;
    if (sum[SUM_W-1]) begin
      sat = '0;
    end else if (sum[SUM_W-2:0] > (SUM_W-1)'(FULL_SCALE)) begin
      sat = VALUE_W'(FULL_SCALE);
    end else begin
      sat = sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      out_q <= sat;
    end
  end

  assign result.curve_value = out_q;

  `CCI_ASSERT_IMPL(a_result_in_range, result.valid, result.curve_value <= FULL_SCALE, "result above full scale")
  `CCI_ASSERT_IMPL(a_ready_when_drained, !result.valid, sample.ready, "input stalled with empty output")
  `CCI_ASSERT_NEXT(a_request_enters, sample.valid && sample.ready, v[1], "accepted request not captured")

endmodule

`default_nettype wire
